@@ hdl/rational_arith_unit_macros.svh @@
// Assertion helpers used by the checker file of the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define RAU_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the standard clock and reset names.
`define RAU_ASSERT(lbl, prop, msg) \
  `RAU_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/rau_pkg.sv @@
package rau_pkg;

  // Result field widths
  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 31;

  // Operation codes; the unused code passes a through
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INC = 3'd5,
    OP_DEC = 3'd6
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_GCD,
    S_DIV,
    S_SCALE,
    S_FIN,
    S_OUT
  } state_e;

endpackage

@@ hdl/rational_arith_unit.sv @@
// Negate, increment, decrement, the unused code and division by zero give the
//   result in the cycle after the request is taken; a zero product goes from S_PROD to S_OUT.
// Add, subtract, multiply and divide otherwise run a binary GCD on one shared
//   subtractor and then two bit-serial divisions by the GCD.
// A new request is taken only after the last result is accepted; ready only when idle.
// Reset (rst_ni, async, active low) returns the sequencer to idle, no result pending.
module rational_arith_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    op_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-2:0]      a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-2:0]      b_den_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [RES_NUM_W-1:0]   res_num_o,
  output logic [RES_DEN_W-1:0]          res_den_o,
  output logic                          status_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = OPERAND_WIDTH - 1;
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(PW);
  localparam logic [CW-1:0] CNT_LAST = CW'(PW - 1);

  state_e state_q, state_d;
  logic [1:0]    step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] sh_q, sh_d;
  logic          divsel_q, divsel_d;

  op_e                 op_q, op_d;
  logic signed [W-1:0] an_q, an_d, bn_q, bn_d;
  logic [DW-1:0]       ad_q, ad_d, bd_q, bd_d;
  logic [PW-1:0]       u_q, u_d, v_q, v_d, g_q, g_d;
  logic [PW-1:0]       rem_q, rem_d, quo_q, quo_d;
  logic [PW-1:0]       t0_q, t0_d, t1_q, t1_d;
  logic                neg_q, neg_d;
  logic signed [PW-1:0] s1_q, s1_d;
  logic signed [RES_NUM_W-1:0] res_num_q, res_num_d;
  logic [RES_DEN_W-1:0] res_den_q, res_den_d;
  logic                status_q, status_d;

  // Request decode
  op_e                 op_in;
  logic [DW-1:0]       ad_in, bd_in;
  logic signed [W:0]   an_in_x, ad_in_x, fast_num;
  logic                div_zero, fast_path, in_fire;

  // Operand views
  logic signed [W:0]   an_x, bn_x, ad_x, bd_x, k1_x, k2_x;
  logic signed [W:0]   mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]       prod_mag;
  logic signed [PW-1:0] sum, num_s;

  // Shared subtractor
  logic [PW+1:0] sub_a, sub_b, sub_y;
  logic          borrow;
  logic [PW:0]   div_shift;
  logic [PW-1:0] rem_nx, quo_nx, div_src0, div_src1;

  // Sequencer conditions
  logic is_addsub, gcd_done, div_last, prod_zero;

  assign in_fire  = in_valid_i && in_ready_o;
  assign op_in    = op_e'(op_i);
  assign ad_in    = (a_den_i == '0) ? DW'(1) : a_den_i;
  assign bd_in    = (b_den_i == '0) ? DW'(1) : b_den_i;
  assign an_in_x  = {a_num_i[W-1], a_num_i};
  assign ad_in_x  = {1'b0, 1'b0, ad_in};
  assign div_zero = (op_in == OP_DIV) && (b_num_i == '0);

  // Fast-path ops on a, and division by zero
  always_comb begin
    fast_num  = an_in_x;
    fast_path = div_zero;
    case (op_in) inside
      OP_NEG: begin
        fast_num  = -an_in_x;
        fast_path = 1'b1;
      end
      OP_INC: begin
        fast_num  = an_in_x + ad_in_x;
        fast_path = 1'b1;
      end
      OP_DEC: begin
        fast_num  = an_in_x - ad_in_x;
        fast_path = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        fast_num = an_in_x;
      end
      default: begin
        fast_path = 1'b1;
      end
    endcase
  end

  assign an_x = {an_q[W-1], an_q};
  assign bn_x = {bn_q[W-1], bn_q};
  assign ad_x = {1'b0, 1'b0, ad_q};
  assign bd_x = {1'b0, 1'b0, bd_q};
  assign k1_x = {1'b0, 1'b0, t0_q[DW-1:0]};
  assign k2_x = {1'b0, 1'b0, t1_q[DW-1:0]};

  assign prod_mag = prod[PW-1] ? $unsigned(-prod) : $unsigned(prod);
  assign sum      = (op_q == OP_SUB) ? s1_q - prod : s1_q + prod;
  assign num_s    = $signed(t0_q);

  assign is_addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
  assign gcd_done  = (u_q == '0) || (v_q == '0);
  assign div_last  = (cnt_q == CNT_LAST);
  assign prod_zero = (t0_q == '0);
  assign div_src0  = is_addsub ? PW'(bd_q) : t0_q;
  assign div_src1  = is_addsub ? PW'(ad_q) : t1_q;

  // Shared multiplier with registered product
  rau_mul #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_rau_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // Steer the shared subtractor: GCD compares u and v, divider trials g
  assign div_shift = {rem_q, quo_q[PW-1]};
  always_comb begin
    if (state_q == S_DIV) begin
      sub_a = {1'b0, div_shift};
      sub_b = {2'b00, g_q};
    end else begin
      sub_a = {2'b00, u_q};
      sub_b = {2'b00, v_q};
    end
  end
  assign sub_y  = sub_a - sub_b;
  assign borrow = sub_y[PW+1];
  assign rem_nx = borrow ? div_shift[PW-1:0] : sub_y[PW-1:0];
  assign quo_nx = {quo_q[PW-2:0], ~borrow};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (fast_path) begin
            state_d = S_OUT;
          end else if ((op_in == OP_ADD) || (op_in == OP_SUB)) begin
            state_d = S_GCD;
          end else begin
            state_d = S_PROD;
          end
        end
      end
      S_PROD: begin
        if (step_q == 2'd2) begin
          state_d = prod_zero ? S_OUT : S_GCD;
        end
      end
      S_GCD: begin
        if (gcd_done) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_last && divsel_q) begin
          state_d = is_addsub ? S_SCALE : S_FIN;
        end
      end
      S_SCALE: begin
        if (step_q == 2'd3) begin
          state_d = S_OUT;
        end
      end
      S_FIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
  end

  // Datapath
  always_comb begin
    step_d    = step_q;
    cnt_d     = cnt_q;
    sh_d      = sh_q;
    divsel_d  = divsel_q;
    op_d      = op_q;
    an_d      = an_q;
    bn_d      = bn_q;
    ad_d      = ad_q;
    bd_d      = bd_q;
    u_d       = u_q;
    v_d       = v_q;
    g_d       = g_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    neg_d     = neg_q;
    s1_d      = s1_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    status_d  = status_q;
    mul_a     = '0;
    mul_b     = '0;

    case (state_q)
      // Capture the request; finish the fast-path ops right away
      S_IDLE: begin
        if (in_fire) begin
          op_d      = op_in;
          an_d      = a_num_i;
          bn_d      = b_num_i;
          ad_d      = ad_in;
          bd_d      = bd_in;
          u_d       = PW'(ad_in);
          v_d       = PW'(bd_in);
          sh_d      = '0;
          step_d    = '0;
          status_d  = div_zero;
          res_num_d = div_zero ? '0 : RES_NUM_W'(fast_num);
          res_den_d = div_zero ? RES_DEN_W'(1) : RES_DEN_W'(ad_in);
        end
      end

      // Form the two products (direct for multiply, cross for divide), split into sign and magnitudes
      S_PROD: begin
        case (step_q)
          2'd0: begin
            mul_a  = an_x;
            mul_b  = (op_q == OP_MUL) ? bn_x : bd_x;
            step_d = 2'd1;
          end
          2'd1: begin
            mul_a  = ad_x;
            mul_b  = (op_q == OP_MUL) ? bd_x : bn_x;
            t0_d   = prod_mag;
            neg_d  = prod[PW-1];
            step_d = 2'd2;
          end
          default: begin
            t1_d   = prod_mag;
            neg_d  = neg_q ^ prod[PW-1];
            u_d    = t0_q;
            v_d    = prod_mag;
            sh_d   = '0;
            step_d = 2'd0;
            if (prod_zero) begin
              res_num_d = '0;
              res_den_d = RES_DEN_W'(1);
            end
          end
        endcase
      end

      // Binary GCD: one shift or one subtract per cycle
      S_GCD: begin
        if (u_q == '0) begin
          g_d = v_q << sh_q;
        end else if (v_q == '0) begin
          g_d = u_q << sh_q;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d  = u_q >> 1;
          v_d  = v_q >> 1;
          sh_d = sh_q + CW'(1);
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (borrow) begin
          v_d = PW'(-sub_y);
        end else begin
          u_d = PW'(sub_y);
        end
        if (gcd_done) begin
          rem_d    = '0;
          quo_d    = div_src0;
          cnt_d    = '0;
          divsel_d = 1'b0;
        end
      end

      // Restoring division by g, one quotient bit per cycle
      S_DIV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + CW'(1);
        if (div_last) begin
          if (!divsel_q) begin
            t0_d     = quo_nx;
            divsel_d = 1'b1;
            rem_d    = '0;
            quo_d    = div_src1;
            cnt_d    = '0;
          end else begin
            t1_d   = quo_nx;
            step_d = '0;
          end
        end
      end

      // Scale numerators and denominator by the lcm factors
      S_SCALE: begin
        case (step_q)
          2'd0: begin
            mul_a  = an_x;
            mul_b  = k1_x;
            step_d = 2'd1;
          end
          2'd1: begin
            mul_a  = bn_x;
            mul_b  = k2_x;
            s1_d   = prod;
            step_d = 2'd2;
          end
          2'd2: begin
            mul_a     = ad_x;
            mul_b     = k1_x;
            res_num_d = RES_NUM_W'(sum);
            step_d    = 2'd3;
          end
          default: begin
            res_den_d = RES_DEN_W'($unsigned(prod));
            step_d    = 2'd0;
          end
        endcase
      end

      // Apply the sign to the reduced magnitude
      S_FIN: begin
        res_num_d = RES_NUM_W'(neg_q ? -num_s : num_s);
        res_den_d = RES_DEN_W'(t1_q);
      end

      default: begin
        step_d = step_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      cnt_q    <= '0;
      sh_q     <= '0;
      divsel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      sh_q     <= sh_d;
      divsel_q <= divsel_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    an_q      <= an_d;
    bn_q      <= bn_d;
    ad_q      <= ad_d;
    bd_q      <= bd_d;
    u_q       <= u_d;
    v_q       <= v_d;
    g_q       <= g_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    t0_q      <= t0_d;
    t1_q      <= t1_d;
    neg_q     <= neg_d;
    s1_q      <= s1_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    status_q  <= status_d;
  end

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign status_o  = status_q;

endmodule

@@ hdl/rau_mul.sv @@
module rau_mul #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic signed [OPERAND_WIDTH:0]     a_i,
  input  logic signed [OPERAND_WIDTH:0]     b_i,
  output logic signed [2*OPERAND_WIDTH-1:0] prod_o
);

  localparam int PW = 2 * OPERAND_WIDTH;

  logic signed [2*OPERAND_WIDTH+1:0] full_prod;
  logic signed [PW-1:0]              prod_q;

  // Multiply; the true product always fits in PW signed bits
  assign full_prod = a_i * b_i;

  // Register the product before it is used
  always_ff @(posedge clk_i) begin
    prod_q <= full_prod[PW-1:0];
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/rau_checker.sv @@
`include "rational_arith_unit_macros.svh"

module rau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] res_num_o,
  input logic [30:0] res_den_o,
  input logic        status_o
);

  // One request in flight: never ready while a result waits
  `RAU_ASSERT(a_excl_busy, !(in_ready_o && out_valid_o), "ready while result pending")

  // Drop ready right after a request is taken
  `RAU_ASSERT(a_busy_after_req, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after request")

  // Division by zero always reports 0/1
  `RAU_ASSERT(a_dbz_value, (out_valid_o && status_o) |-> (res_num_o == 32'd0 && res_den_o == 31'd1), "bad div-by-zero result")

  // Hold a stalled result
  `RAU_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(res_num_o) && $stable(res_den_o)), "result changed while stalled")

  // One result per request
  `RAU_ASSERT(a_single_out, (out_valid_o && out_ready_i) |=> !out_valid_o, "repeated result")

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
